// ----- src/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg
// types, codes and defaults shared by the sorted list insert block
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 6;
    localparam int POSITION_W = 6;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } in_t;

    typedef struct packed {
        logic [POSITION_W-1:0]     position;
        logic signed [VALUE_W-1:0] data;
        logic [COUNT_W-1:0]        count;
        logic [STATUS_W-1:0]       status;
    } out_t;

    typedef struct packed {
        logic open;
        logic ge;
        logic gt;
    } cell_flags_t;

endpackage

`default_nettype wire

// ----- src/sli_cell.sv -----
// ----------------------------------------------------------------------------
// sli_cell
// one list slot: compares its entry with the new value and on an insert
// keeps its entry, takes the new value or takes its left neighbor's entry
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell (
    input  wire logic                              aclk,
    input  wire logic                              shift_en,
    input  wire logic                              valid,
    input  wire logic signed [sli_pkg::VALUE_W-1:0] value,
    input  wire logic signed [sli_pkg::VALUE_W-1:0] left_data,
    input  wire logic                              left_open,
    output logic signed [sli_pkg::VALUE_W-1:0]      data,
    output sli_pkg::cell_flags_t                    flags
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic                      ge;
    logic                      gt;
    logic                      open;

    assign ge   = valid && (data_reg >= value);
    assign gt   = valid && (data_reg > value);
    assign open = !valid || ge;

    always_comb begin
        data_next = data_reg;
        if (shift_en && open) begin
            if (left_open) begin
                data_next = left_data;
            end else begin
                data_next = value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign flags = '{open: open, ge: ge, gt: gt};

endmodule

`default_nettype wire

// ----- src/sli_locate.sv -----
// ----------------------------------------------------------------------------
// sli_locate
// turns the thermometer of open slots into the index of the first one
// ----------------------------------------------------------------------------
`default_nettype none

module sli_locate #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  wire logic [CAPACITY-1:0]         open_vec,
    output logic [$clog2(CAPACITY)-1:0]      first_idx
);
    import sli_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic [CAPACITY-1:0] edge_vec;

    assign edge_vec = open_vec & ~{open_vec[CAPACITY-2:0], 1'b0};

    always_comb begin
        first_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (edge_vec[k]) begin
                first_idx = first_idx | IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sorted_list_insert.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert
// ascending list of signed values held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// Each transaction is an insert or a read and gives one result. The block
// takes one transaction per cycle unless the output stalls. The transaction
// is registered; then, in the next cycle, every cell compares its entry with
// the value. When the output register is free or drained, the cells from the
// insert position up shift by one slot on an insert to a non-full list, while
// the result is written to the output register. A full list drops an insert
// with status full; a read at or beyond the count returns status range and
// data zero. No clearing is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sli_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sli_pkg::out_t      m_data
);
    import sli_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (IDX_W > POSITION_W) ? IDX_W : POSITION_W;
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    in_t              item_reg;
    in_t              item_next;
    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    out_t             out_reg;
    out_t             out_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic                      exec;
    logic                      full;
    logic                      shift_en;
    logic                      gt_any;
    logic [CAPACITY-1:0]       open_vec;
    logic [CAPACITY-1:0]       gt_vec;
    logic [IDX_W-1:0]          first_idx;
    logic [IDX_W-1:0]          ins_pos;
    logic                      rd_ok;
    logic signed [VALUE_W-1:0] rd_data;

    logic signed [VALUE_W-1:0] cell_data  [CAPACITY];
    cell_flags_t               cell_flags [CAPACITY];

    assign exec     = busy_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !busy_reg || exec;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign shift_en = exec && (item_reg.op == OP_INSERT) && !full;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic                      left_open;
        logic signed [VALUE_W-1:0] left_data;

        if (k == 0) begin : g_head
            assign left_open = 1'b0;
            assign left_data = item_reg.value;
        end else begin : g_body
            assign left_open = cell_flags[k-1].open;
            assign left_data = cell_data[k-1];
        end

        sli_cell u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .valid     (CNT_W'(k) < count_reg),
            .value     (item_reg.value),
            .left_data (left_data),
            .left_open (left_open),
            .data      (cell_data[k]),
            .flags     (cell_flags[k])
        );

        assign open_vec[k] = cell_flags[k].open;
        assign gt_vec[k]   = cell_flags[k].gt;
    end

    sli_locate #(
        .CAPACITY (CAPACITY)
    ) u_locate (
        .open_vec  (open_vec),
        .first_idx (first_idx)
    );

    assign gt_any = |gt_vec;

    always_comb begin
        if (count_reg == '0 || cell_flags[0].ge) begin
            ins_pos = '0;
        end else if (!gt_any) begin
            ins_pos = IDX_W'(count_reg);
        end else begin
            ins_pos = first_idx;
        end
    end

    // read path
    assign rd_ok = CW'(item_reg.index) < CW'(count_reg);

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (k < (1 << INDEX_W) && item_reg.index == INDEX_W'(k)) begin
                rd_data = cell_data[k];
            end
        end
    end

    always_comb begin
        out_next = out_reg;
        count_next = count_reg;
        if (exec) begin
            if (item_reg.op == OP_INSERT) begin
                out_next.data = item_reg.value;
                if (full) begin
                    out_next.position = '0;
                    out_next.status   = ST_FULL;
                end else begin
                    out_next.position = POSITION_W'(PW'(ins_pos));
                    out_next.status   = ST_OK;
                    count_next        = count_reg + CNT_W'(1);
                end
            end else begin
                out_next.position = item_reg.index;
                if (rd_ok) begin
                    out_next.data   = rd_data;
                    out_next.status = ST_OK;
                end else begin
                    out_next.data   = '0;
                    out_next.status = ST_RANGE;
                end
            end
            out_next.count = COUNT_W'(CW'(count_next));
        end
    end

    always_comb begin
        item_next = item_reg;
        busy_next = busy_reg;
        if (s_valid && s_ready) begin
            item_next = s_data;
            busy_next = 1'b1;
        end else if (exec) begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted list insert block
// ----------------------------------------------------------------------------
// Starts with a table of hand-picked transactions on an empty list. The table
// covers the value extremes, inserts equal to the first, last and middle
// entries, and reads in range, at the count and at the top index. After that,
// random inserts mixed with reads fill the list to capacity; random reads and
// dropped inserts follow. Each result is compared field by field against the
// table row or an in-bench copy of the list. Both handshakes stall at random.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 740;
    localparam int QUIET_LIMIT  = 500;
    localparam int TAIL_CYCLES  = 8;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t result;
    } stim_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    logic signed [VALUE_W-1:0] sorted_vals [LIST_DEPTH];
    int        sorted_len = 0;
    out_t      pending_results [$];
    stim_row_t directed_rows [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  n_inserts      = 0;
    int  n_dropped      = 0;
    int  n_reads        = 0;
    int  n_out_of_range = 0;
    bit  s_burst        = 1'b0;

    sorted_list_insert #(.CAPACITY(LIST_DEPTH)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic out_t predict_list_step(in_t item);
        out_t                      res;
        logic signed [VALUE_W-1:0] v;
        int                        slot;
        int                        k;
        res = '0;
        v   = item.value;
        if (item.op == OP_INSERT) begin
            n_inserts++;
            res.data = v;
            if (sorted_len >= LIST_DEPTH) begin
                n_dropped++;
                res.status = ST_FULL;
            end else begin
                if (sorted_len == 0 || sorted_vals[0] >= v) begin
                    slot = 0;
                end else if (sorted_vals[sorted_len-1] <= v) begin
                    slot = sorted_len;
                end else begin
                    slot = 1;
                    while (slot < sorted_len && sorted_vals[slot] < v)
                        slot++;
                end
                for (k = sorted_len; k > slot; k--)
                    sorted_vals[k] = sorted_vals[k-1];
                sorted_vals[slot] = v;
                sorted_len++;
                res.position = POSITION_W'(slot);
                res.status   = ST_OK;
            end
        end else begin
            n_reads++;
            res.position = item.index;
            if (int'(item.index) < sorted_len) begin
                res.data   = sorted_vals[item.index];
                res.status = ST_OK;
            end else begin
                n_out_of_range++;
                res.status = ST_RANGE;
            end
        end
        res.count = COUNT_W'(sorted_len);
        return res;
    endfunction

    function automatic in_t draw_list_op();
        in_t item;
        item.value = $urandom();
        item.index = INDEX_W'($urandom_range(0, 63));
        if (sorted_len < LIST_DEPTH)
            item.op = ($urandom_range(0, 2) == 0) ? OP_INSERT : OP_READ;
        else
            item.op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_READ;
        if (item.op == OP_READ) begin
            if (sorted_len > 0 && $urandom_range(0, 3) != 0)
                item.index = INDEX_W'($urandom_range(0, sorted_len - 1));
        end else begin
            case ($urandom_range(0, 3))
                1: item.value = int'($urandom_range(0, 8)) - 4;
                2: begin
                    case ($urandom_range(0, 3))
                        0:       item.value = VAL_MIN;
                        1:       item.value = VAL_MAX;
                        2:       item.value = -1;
                        default: item.value = 0;
                    endcase
                end
                3: begin
                    if (sorted_len > 0)
                        item.value = sorted_vals[$urandom_range(0, sorted_len - 1)]
                                     + (int'($urandom_range(0, 2)) - 1);
                end
                default: ;
            endcase
        end
        return item;
    endfunction

    task automatic add_check(input logic op, input logic signed [VALUE_W-1:0] value,
                             input logic [INDEX_W-1:0] index,
                             input logic [POSITION_W-1:0] position,
                             input logic signed [VALUE_W-1:0] data,
                             input logic [COUNT_W-1:0] count,
                             input logic [STATUS_W-1:0] status);
        stim_row_t row;
        row.item   = '{op: op, value: value, index: index};
        row.typed  = 1'b1;
        row.result = '{position: position, data: data, count: count, status: status};
        directed_rows.push_back(row);
    endtask

    task automatic add_free(input logic op, input logic signed [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
        stim_row_t row;
        row.item   = '{op: op, value: value, index: index};
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input in_t item, input bit typed, input out_t typed_result);
        int   gap;
        out_t predicted;
        gap = s_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_list_step(item);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    initial begin
        int n;
        add_check(OP_READ,   0,       0,  0, 0,       0, ST_RANGE);
        add_check(OP_READ,   -1,      63, 63, 0,      0, ST_RANGE);
        add_check(OP_INSERT, 0,       63, 0, 0,       1, ST_OK);
        add_check(OP_INSERT, VAL_MAX, 0,  1, VAL_MAX, 2, ST_OK);
        add_check(OP_INSERT, VAL_MIN, 0,  0, VAL_MIN, 3, ST_OK);
        // equal to a middle entry, then to the last, then to the first
        add_free(OP_INSERT, 0,       0);
        add_free(OP_INSERT, VAL_MAX, 0);
        add_free(OP_INSERT, VAL_MIN, 0);
        add_free(OP_INSERT, -1,      21);
        add_free(OP_INSERT, 1,       42);
        add_check(OP_READ,   0,       0,  0, VAL_MIN, 8, ST_OK);
        add_check(OP_READ,   0,       7,  7, VAL_MAX, 8, ST_OK);
        add_check(OP_READ,   0,       8,  8, 0,       8, ST_RANGE);
        add_free(OP_READ,   32'sh5A5A_5A5A, 3);
        add_free(OP_READ,   0,       4);
        add_check(OP_READ,   VAL_MAX, 63, 63, 0,      8, ST_RANGE);
        add_free(OP_INSERT, 0,       0);
        add_free(OP_READ,   0,       5);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 32 == 0)
                s_burst = ($urandom_range(0, 3) == 0);
            send_item(draw_list_op(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d inserts (%0d dropped on a full list), %0d reads (%0d beyond count)",
                 n_inserts, n_dropped, n_reads, n_out_of_range);
        $display("final list length %0d of %0d", sorted_len, LIST_DEPTH);
        if (mismatch_count == 0)
            $display("sorted_list_insert: match");
        else
            $display("sorted_list_insert: mismatch");
        $finish;
    end

    initial begin
        int  stall;
        int  taken;
        bit  m_burst;
        taken   = 0;
        m_burst = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 32 == 0)
                m_burst = ($urandom_range(0, 3) == 0);
            stall = m_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction: position %0d data %0d count %0d status %0d",
                       m_data.position, m_data.data, m_data.count, m_data.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, m_data.position);
                    mismatch_count++;
                end
                if (m_data.data !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, m_data.data);
                    mismatch_count++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_data.count);
                    mismatch_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("sorted_list_insert: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
src/sli_pkg.sv
src/sli_cell.sv
src/sli_locate.sv
src/sorted_list_insert.sv
bench/tb_top.sv
